/* hw/rtl/rle2_pkg.sv */
package rle2_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] BYTE_ZERO = 8'd0;
  localparam logic [7:0] BYTE_RUN  = 8'd128;
  localparam logic [7:0] BYTE_ESC  = 8'd129;
  localparam logic [7:0] BYTE_LONG = 8'd255;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SKIP   = 3'd1,
    PH_WIDTH  = 3'd2,
    PH_HEIGHT = 3'd3,
    PH_COUNT  = 3'd4,
    PH_VALUE  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    CMD_SINGLE = 2'd0,
    CMD_TWO    = 2'd1,
    CMD_LONG   = 2'd2,
    CMD_MAX    = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] aux;
    logic [7:0] val;
    logic       done;
  } cmd_t;

  function automatic logic [7:0] esc_or_val(input logic [7:0] v, input logic second);
    esc_or_val = (v[7] && !second) ? BYTE_ESC : v;
  endfunction

  function automatic logic [2:0] cmd_len(input cmd_t c);
    logic [2:0] s;
    s = c.val[7] ? 3'd2 : 3'd1;
    unique case (c.kind)
      CMD_SINGLE: cmd_len = s;
      CMD_TWO:    cmd_len = 3'd2;
      CMD_LONG:   cmd_len = 3'd4;
      CMD_MAX:    cmd_len = 3'd4 + s;
      default:    cmd_len = 3'd1;
    endcase
  endfunction

  function automatic logic [7:0] cmd_byte(input cmd_t c, input logic [2:0] idx);
    unique case (c.kind)
      CMD_SINGLE: cmd_byte = esc_or_val(c.val, idx[0]);
      CMD_TWO:    cmd_byte = idx[0] ? c.val : c.aux;
      default: begin
        unique case (idx)
          3'd0:           cmd_byte = BYTE_LONG;
          3'd1, 3'd3:     cmd_byte = c.val;
          3'd2:           cmd_byte = c.aux;
          default:        cmd_byte = esc_or_val(c.val, idx[0]);
        endcase
      end
    endcase
  endfunction

endpackage

/* hw/rtl/rle2_front.sv */
module rle2_front
  import rle2_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  width_q, width_d;
  logic [15:0] total_q, total_d;
  logic [7:0]  run_q, run_d;
  logic [16:0] cells_q, cells_d;
  logic [16:0] sum;
  logic        fire;

  assign in_ready_o = !full_i;
  assign fire       = in_valid_i && in_ready_o;
  assign sum        = cells_q + 17'(run_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      width_q <= '0;
      total_q <= '0;
      run_q   <= '0;
      cells_q <= '0;
    end else begin
      phase_q <= phase_d;
      width_q <= width_d;
      total_q <= total_d;
      run_q   <= run_d;
      cells_q <= cells_d;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    width_d    = width_q;
    total_d    = total_q;
    run_d      = run_q;
    cells_d    = cells_q;
    push_o     = 1'b0;
    cmd_o.kind = CMD_TWO;
    cmd_o.aux  = in_byte_i;
    cmd_o.val  = BYTE_ZERO;
    cmd_o.done = 1'b0;
    if (fire) begin
      unique case (phase_q)
        PH_SKIP: phase_d = PH_WIDTH;
        PH_WIDTH: begin
          width_d = in_byte_i;
          push_o  = 1'b1;
          phase_d = PH_HEIGHT;
        end
        PH_HEIGHT: begin
          total_d = 16'(width_q) * 16'(in_byte_i);
          cells_d = '0;
          push_o  = 1'b1;
          phase_d = PH_COUNT;
        end
        PH_COUNT: begin
          run_d   = in_byte_i;
          phase_d = PH_VALUE;
        end
        PH_VALUE: begin
          cmd_o.val = in_byte_i;
          push_o    = (run_q != 8'd0);
          if (run_q == 8'd1) begin
            cmd_o.kind = CMD_SINGLE;
          end else if (!run_q[7]) begin
            cmd_o.kind = CMD_TWO;
            cmd_o.aux  = run_q | BYTE_RUN;
          end else if (run_q != BYTE_LONG) begin
            cmd_o.kind = CMD_LONG;
            cmd_o.aux  = run_q + 8'd1;
          end else begin
            cmd_o.kind = CMD_MAX;
            cmd_o.aux  = BYTE_LONG;
          end
          if (sum >= 17'(total_q)) begin
            cmd_o.done = 1'b1;
            cells_d    = '0;
            phase_d    = PH_START;
          end else begin
            cells_d = sum;
            phase_d = PH_COUNT;
          end
        end
        default: begin
          if (in_byte_i == BYTE_ZERO) begin
            phase_d = PH_SKIP;
          end else begin
            width_d = in_byte_i;
            push_o  = 1'b1;
            phase_d = PH_HEIGHT;
          end
        end
      endcase
    end
  end

endmodule

/* hw/rtl/rle2_queue.sv */
module rle2_queue
  import rle2_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output cmd_t head_o
);

  cmd_t             slot_q [QDEPTH];
  logic [QAW-1:0]   wr_q, rd_q;
  logic [QAW:0]     cnt_q;

  assign full_o  = (cnt_q == (QAW+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QAW+1)'(push_i) - (QAW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= cmd_i;
  end

endmodule

/* hw/rtl/rle2_back.sv */
module rle2_back
  import rle2_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       layer_done_o,
  output logic       last_o
);

  logic       valid_q, valid_d;
  logic [2:0] idx_q, idx_d;
  logic [7:0] byte_q;
  logic       done_q, last_q;
  logic       load, fin;

  assign load = (!valid_q || out_ready_i) && !empty_i;
  assign fin  = (idx_q == cmd_len(head_i) - 3'd1);
  assign pop_o = load && fin;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = fin ? 3'd0 : idx_q + 3'd1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= cmd_byte(head_i, idx_q);
      last_q <= fin;
      done_q <= fin && head_i.done;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign layer_done_o = done_q;
  assign last_o       = last_q;

endmodule

/* hw/rtl/rle_pair_to_rle2_transcoder_top.sv */
// Converts an old run-length layer stream, one byte per request, into the new
// layer encoding, one byte per result request with layer_done and last flags.
// The front takes an input byte every cycle while its four-entry command queue
// has room; bytes that produce nothing (zero-run marker, skipped byte, run
// count, zero-count pair) wait only while the queue is full. The output
// serializer sends one byte per cycle while the result side is ready and the
// queue holds a command; a byte produces 0 to 6 results, and that serializer
// sets the sustained rate. The first result of a byte passes through the
// command queue and the output byte register before it is offered.
module rle_pair_to_rle2_transcoder_top
  import rle2_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       layer_done_o,
  output logic       last_o
);

  logic push, pop, full, empty;
  cmd_t cmd, head;

  rle2_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  rle2_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  rle2_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .layer_done_o (layer_done_o),
    .last_o       (last_o)
  );

endmodule

/* hw/rtl/rle2_checker.sv */
module rle2_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] in_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       layer_done_o,
  input logic       last_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_byte_i))
    else $error("input request changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(out_byte_o) && $stable(layer_done_o) && $stable(last_o))
    else $error("result payload changed while stalled");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && layer_done_o |-> last_o)
    else $error("layer end not on last byte of a request");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("gap inside the bytes of one request");

endmodule

bind rle_pair_to_rle2_transcoder_top rle2_checker u_rle2_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .in_byte_i    (in_byte_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_byte_o   (out_byte_o),
  .layer_done_o (layer_done_o),
  .last_o       (last_o)
);
